// ----- src/dlt_pkg.sv -----
// Shared types, codes and reset values for the DHCP lease table unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dlt_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned SEC_W      = 32;
  localparam int unsigned HOST_W     = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ACNT_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned       DEF_LEASE_ENTRIES = 64;
  localparam logic [IP_W-1:0]   DEF_POOL_BASE     = 32'hC0A8_0A00;
  localparam logic [HOST_W-1:0] DEF_HOST_OFFSET   = 8'd100;
  localparam logic [SEC_W-1:0]  DEF_LEASE_SECONDS = 32'd3600;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECONDS = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_DISCOVER = 2'd0,
    FN_REQUEST  = 2'd1,
    FN_RELEASE  = 2'd2,
    FN_TICK     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OFFERED   = 3'd0,
    ST_ACKED     = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_UNMATCHED = 3'd5,
    ST_TICK      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2,
    S_FINISH = 2'd3
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  addr;
    logic [SEC_W-1:0] expiry;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/dlt_ifs.sv -----
// Valid/ready channel interfaces of the DHCP lease table unit: command in,
// result out and configuration write. Depends on dlt_pkg.
`default_nettype none

interface dlt_in_if;
  import dlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [MAC_W-1:0]  hw_addr;
  logic [IP_W-1:0]   requested_ip;
  modport source (output valid, func, hw_addr, requested_ip, input ready);
  modport sink   (input valid, func, hw_addr, requested_ip, output ready);
endinterface

interface dlt_out_if;
  import dlt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IP_W-1:0]     lease_address;
  logic [ACNT_W-1:0]   active_count;
  modport source (output valid, status, lease_address, active_count, input ready);
  modport sink   (input valid, status, lease_address, active_count, output ready);
endinterface

interface dlt_cfg_if;
  import dlt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/dlt_ctrl.sv -----
// Controller of the lease table: sequences accept, table scan, update and
// result hand-off. Depends on dlt_pkg.
`default_nettype none

module dlt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output dlt_pkg::cmd_t cmd,
  input  dlt_pkg::sts_t sts
);
  import dlt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_FINISH;
      S_FINISH: if (sts.out_free) state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.scan   = (state_r == S_SCAN);
    cmd.update = (state_r == S_UPDATE);
    cmd.emit   = (state_r == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/dlt_dpath.sv -----
// Datapath of the lease table: config and time registers, entry memory with
// a pipelined one-entry-per-cycle scan, active bits and the result register.
// Depends on dlt_pkg.
`default_nettype none

module dlt_dpath #(
  parameter int unsigned LEASE_ENTRIES = dlt_pkg::DEF_LEASE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dlt_pkg::cmd_t                  cmd,
  output dlt_pkg::sts_t                  sts,
  input  logic [dlt_pkg::FUNC_W-1:0]     in_func,
  input  logic [dlt_pkg::MAC_W-1:0]      in_hw_addr,
  input  logic [dlt_pkg::IP_W-1:0]       in_requested_ip,
  input  logic                           cfg_valid,
  input  logic [dlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [dlt_pkg::STATUS_W-1:0]   out_status,
  output logic [dlt_pkg::IP_W-1:0]       out_lease_address,
  output logic [dlt_pkg::ACNT_W-1:0]     out_active_count
);
  import dlt_pkg::*;

  localparam int unsigned IDX_W   = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
  localparam int unsigned CTR_W   = $clog2(LEASE_ENTRIES + 1);
  localparam int unsigned HSUM_W  = HOST_W + 1;
  localparam logic [CTR_W-1:0] END_CTR = CTR_W'(LEASE_ENTRIES);

  // configuration and time
  logic [IP_W-1:0]   pool_base_r;
  logic [HOST_W-1:0] host_offset_r;
  logic [SEC_W-1:0]  lease_sec_r;
  logic [SEC_W-1:0]  now_r;

  // captured command
  func_t            func_r;
  logic [MAC_W-1:0] mac_r;
  logic [IP_W-1:0]  req_r;

  // table
  entry_t                   mem [LEASE_ENTRIES];
  entry_t                   rd_q_r;
  logic [LEASE_ENTRIES-1:0] active_r;
  logic [CTR_W-1:0]         cnt_r;

  // scan pipeline
  logic [CTR_W-1:0] rd_ctr_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             match_r;
  logic [IDX_W-1:0] match_idx_r;
  logic [IP_W-1:0]  match_addr_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  // result
  status_t         res_status_r;
  logic [IP_W-1:0] res_addr_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [IP_W-1:0] out_addr_r;
  logic [ACNT_W-1:0] out_cnt_r;

  logic cmp_act, key_hit, free_hit, issue;

  logic [SEC_W:0]   end_sum;
  logic [SEC_W-1:0] expiry_new;
  logic [IP_W-1:0]  new_addr;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  logic             set_act, clr_act, cnt_inc, cnt_dec, now_inc;
  logic [IDX_W-1:0] act_idx;
  status_t          res_status_nxt;
  logic [IP_W-1:0]  res_addr_nxt;

  // compare stage: one entry per cycle from the registered memory output
  assign cmp_act  = active_r[cmp_idx_r];
  assign key_hit  = cmp_vld_r && cmp_act && (rd_q_r.mac == mac_r) &&
                    ((func_r != FN_REQUEST) || (rd_q_r.addr == req_r));
  assign free_hit = cmp_vld_r && (func_r == FN_DISCOVER) &&
                    (!cmp_act || (rd_q_r.expiry < now_r));
  // stop issuing reads once the first key match is seen
  assign issue    = cmd.scan && (func_r != FN_TICK) && !match_r && !key_hit &&
                    (rd_ctr_r != END_CTR);

  assign sts.scan_done = (func_r == FN_TICK) || match_r ||
                         ((rd_ctr_r == END_CTR) && !cmp_vld_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign end_sum    = {1'b0, now_r} + {1'b0, lease_sec_r};
  assign expiry_new = end_sum[SEC_W] ? '1 : end_sum[SEC_W-1:0];
  assign new_addr   = pool_base_r |
                      IP_W'(HSUM_W'(host_offset_r) + HSUM_W'(free_idx_r));

  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = match_idx_r;
    wr_data        = '{mac: mac_r, addr: match_addr_r, expiry: expiry_new};
    set_act        = 1'b0;
    clr_act        = 1'b0;
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    now_inc        = 1'b0;
    act_idx        = match_idx_r;
    res_status_nxt = ST_TICK;
    res_addr_nxt   = '0;
    case (func_r)
      FN_DISCOVER: begin
        if (match_r) begin
          wr_en          = 1'b1;
          res_status_nxt = ST_OFFERED;
          res_addr_nxt   = match_addr_r;
        end else if (free_r) begin
          wr_en          = 1'b1;
          wr_idx         = free_idx_r;
          wr_data        = '{mac: mac_r, addr: new_addr, expiry: expiry_new};
          set_act        = 1'b1;
          act_idx        = free_idx_r;
          // an expired entry is reclaimed while still active
          cnt_inc        = !active_r[free_idx_r];
          res_status_nxt = ST_OFFERED;
          res_addr_nxt   = new_addr;
        end else begin
          res_status_nxt = ST_EXHAUSTED;
        end
      end
      FN_REQUEST: begin
        if (match_r) begin
          wr_en          = 1'b1;
          wr_data        = '{mac: mac_r, addr: req_r, expiry: expiry_new};
          res_status_nxt = ST_ACKED;
          res_addr_nxt   = req_r;
        end else begin
          res_status_nxt = ST_REFUSED;
        end
      end
      FN_RELEASE: begin
        if (match_r) begin
          clr_act        = 1'b1;
          cnt_dec        = 1'b1;
          res_status_nxt = ST_RELEASED;
        end else begin
          res_status_nxt = ST_UNMATCHED;
        end
      end
      FN_TICK: begin
        now_inc        = (now_r != '1);
        res_status_nxt = ST_TICK;
      end
    endcase
  end

  // entry storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      rd_q_r <= mem[rd_ctr_r[IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= DEF_POOL_BASE;
      host_offset_r <= DEF_HOST_OFFSET;
      lease_sec_r   <= DEF_LEASE_SECONDS;
      now_r         <= '0;
      active_r      <= '0;
      cnt_r         <= '0;
      cmp_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POOL_BASE:     pool_base_r   <= cfg_data[IP_W-1:0];
          CFG_HOST_OFFSET:   host_offset_r <= cfg_data[HOST_W-1:0];
          CFG_LEASE_SECONDS: lease_sec_r   <= cfg_data[SEC_W-1:0];
          default: ;
        endcase
      end
      cmp_vld_r <= issue;
      if (cmd.update) begin
        if (set_act) active_r[act_idx] <= 1'b1;
        if (clr_act) active_r[act_idx] <= 1'b0;
        if (cnt_inc) cnt_r <= cnt_r + 1'b1;
        if (cnt_dec) cnt_r <= cnt_r - 1'b1;
        if (now_inc) now_r <= now_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= func_t'(in_func);
      mac_r    <= in_hw_addr;
      req_r    <= in_requested_ip;
      rd_ctr_r <= '0;
      match_r  <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      if (issue) begin
        cmp_idx_r <= rd_ctr_r[IDX_W-1:0];
        rd_ctr_r  <= rd_ctr_r + 1'b1;
      end
      if (key_hit) begin
        match_r      <= 1'b1;
        match_idx_r  <= cmp_idx_r;
        match_addr_r <= rd_q_r.addr;
      end
      // keep the lowest free or expired entry only
      if (free_hit && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.update) begin
      res_status_r <= res_status_nxt;
      res_addr_r   <= res_addr_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_cnt_r    <= ACNT_W'(cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_lease_address = out_addr_r;
  assign out_active_count  = out_cnt_r;

endmodule

`default_nettype wire

// ----- src/dhcp_lease_table_unit.sv -----
// DHCP lease table unit. A command is taken in idle and passes through the
// entry scan, which reads one entry a cycle through the single memory port,
// the table update and the result hand-off; a tick skips the scan.
// One command in flight; the next command is taken only after the result has
// been handed off, which waits while the result stalls.
// Reset (rst_n low, synchronous) clears active bits, count, seconds and the
// config registers to defaults; entry storage is not cleared.
`default_nettype none

module dhcp_lease_table_unit #(
  parameter int unsigned LEASE_ENTRIES = dlt_pkg::DEF_LEASE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  dlt_in_if.sink    in_ch,
  dlt_out_if.source out_ch,
  dlt_cfg_if.sink   cfg_ch
);
  import dlt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dlt_dpath #(
    .LEASE_ENTRIES (LEASE_ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_hw_addr        (in_ch.hw_addr),
    .in_requested_ip   (in_ch.requested_ip),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_lease_address (out_ch.lease_address),
    .out_active_count  (out_ch.active_count)
  );

endmodule

`default_nettype wire

// ----- src/dlt_checker.sv -----
// Port-level checks of the DHCP lease table unit, bound to the top level.
// Depends on dlt_pkg and dhcp_lease_table_unit.
`default_nettype none

module dlt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dlt_pkg::STATUS_W-1:0] out_status,
  input logic [dlt_pkg::IP_W-1:0]     out_lease_address,
  input logic [dlt_pkg::ACNT_W-1:0]   out_active_count
);
  import dlt_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_lease_address) && $stable(out_active_count))
    else $error("stalled result changed");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OFFERED) && (out_status != ST_ACKED)
      |-> out_lease_address == '0)
    else $error("address given without offer or ack");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

endmodule

bind dhcp_lease_table_unit dlt_checker u_dlt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_lease_address (out_ch.lease_address),
  .out_active_count  (out_ch.active_count)
);

`default_nettype wire
